// ===== rtl/core/dct_coefficient_pair_stego_assert.svh =====
// ----------------------------------------------------------------------------
// DCT coefficient pair stego - assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DCT_COEFFICIENT_PAIR_STEGO_ASSERT_SVH
`define DCT_COEFFICIENT_PAIR_STEGO_ASSERT_SVH

// prop must hold at every clock edge out of reset
`define DCPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// cons must hold in the same cycle as ante
`define DCPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dcps_pkg.sv =====
// ----------------------------------------------------------------------------
// dcps_pkg
// Shared constants, basis weight tables and interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dcps_pkg;

  localparam int BlockDim    = 8;
  localparam int BlockPixels = BlockDim * BlockDim;
  localparam int PosW        = $clog2(BlockPixels);
  localparam int FracBits    = 10;

  localparam int RowA = 6;
  localparam int ColA = 7;
  localparam int RowB = 5;
  localparam int ColB = 1;

  // weight magnitude stays below 1.0, so Q(FracBits) plus sign
  localparam int WW     = FracBits + 2;
  localparam int DiffWW = FracBits + 3;
  // 64 * 255 * 2^FracBits plus sign
  localparam int CW     = FracBits + 15;
  // (b - a) +/- intensity
  localparam int DW     = CW + 2;
  localparam int PW     = DW + DiffWW;
  localparam int TW     = PW + 1;
  localparam int Shift  = 2 * FracBits + 1;

  localparam int OutDepth = 4;
  localparam int OutPtrW  = $clog2(OutDepth);

  // cos(m*pi/16) in Q30, m = 0..8
  localparam longint CosQ30 [9] = '{
    64'sd1073741824, 64'sd1053110176, 64'sd992008094, 64'sd892783698,
    64'sd759250125,  64'sd596538995,  64'sd410903207, 64'sd209476638,
    64'sd0
  };

  typedef logic signed [WW-1:0]     wtab_t [BlockPixels];
  typedef logic signed [DiffWW-1:0] dtab_t [BlockPixels];

  function automatic longint cos_angle(int unsigned k);
    int unsigned m;
    m = k & 31;
    if (m > 16) m = 32 - m;
    if (m > 8) return -CosQ30[16-m];
    return CosQ30[m];
  endfunction

  function automatic longint weight(int unsigned u, int unsigned v,
                                    int unsigned r, int unsigned c);
    longint          p;
    longint unsigned mag;
    longint unsigned q;
    int unsigned     sh;
    p   = cos_angle((2 * r + 1) * u) * cos_angle((2 * c + 1) * v);
    mag = (p < 0) ? longint'(-p) : longint'(p);
    sh  = 62 - FracBits;
    q   = (mag + (64'd1 << (sh - 1))) >> sh;
    return (p < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic wtab_t gen_wtab(int unsigned u, int unsigned v);
    wtab_t tab;
    for (int i = 0; i < BlockPixels; i++) begin
      tab[i] = WW'(weight(u, v, i / BlockDim, i % BlockDim));
    end
    return tab;
  endfunction

  function automatic dtab_t gen_dtab();
    dtab_t tab;
    for (int i = 0; i < BlockPixels; i++) begin
      tab[i] = DiffWW'(weight(RowA, ColA, i / BlockDim, i % BlockDim)
                       - weight(RowB, ColB, i / BlockDim, i % BlockDim));
    end
    return tab;
  endfunction

  localparam wtab_t WTabA = gen_wtab(RowA, ColA);
  localparam wtab_t WTabB = gen_wtab(RowB, ColB);
  // basis(a) - basis(b): the pixel delta is d * this, with db = -da
  localparam dtab_t WTabD = gen_dtab();

  typedef struct packed {
    logic                 kind;
    logic                 msg_bit;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
  } job_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic            wr_bank;
    logic            rd_bank;
  } jobq_stat_t;

  typedef struct packed {
    logic            en;
    logic [PosW:0]   addr;
    logic [7:0]      data;
  } pix_wr_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       found;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/dcps_front.sv =====
// ----------------------------------------------------------------------------
// dcps_front
// Takes pixel beats, stores them and accumulates both DCT coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module dcps_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [15:0]         s_axis_tdata_i,
  input  wire logic                s_axis_tuser_i,
  input  wire dcps_pkg::jobq_stat_t q_stat_i,
  output logic                     push_o,
  output dcps_pkg::job_t           push_job_o,
  output dcps_pkg::pix_wr_t        pix_wr_o
);
  import dcps_pkg::*;

  logic                 accept;
  logic [PosW-1:0]      pos_q;
  logic signed [CW-1:0] acc_a_q, acc_b_q;
  logic signed [CW-1:0] sum_a, sum_b;
  logic signed [8:0]    pix_s;
  logic signed [WW-1:0] w_a, w_b;
  logic signed [CW-1:0] term_a, term_b;
  logic                 blk_end;

  assign s_axis_tready_o = !q_stat_i.full;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign blk_end = (pos_q == PosW'(BlockPixels - 1));

  assign pix_s  = $signed({1'b0, s_axis_tdata_i[7:0]});
  assign w_a    = WTabA[pos_q];
  assign w_b    = WTabB[pos_q];
  assign term_a = CW'(pix_s) * CW'(w_a);
  assign term_b = CW'(pix_s) * CW'(w_b);
  assign sum_a  = acc_a_q + term_a;
  assign sum_b  = acc_b_q + term_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      acc_a_q <= '0;
      acc_b_q <= '0;
    end else if (accept) begin
      pos_q <= pos_q + PosW'(1);
      if (blk_end) begin
        acc_a_q <= '0;
        acc_b_q <= '0;
      end else begin
        acc_a_q <= sum_a;
        acc_b_q <= sum_b;
      end
    end
  end

  assign push_o             = accept && blk_end;
  assign push_job_o.kind    = s_axis_tuser_i;
  assign push_job_o.msg_bit = s_axis_tdata_i[8];
  assign push_job_o.coef_a  = sum_a;
  assign push_job_o.coef_b  = sum_b;

  // block buffer bank follows the job slot the block will occupy
  assign pix_wr_o.en   = accept;
  assign pix_wr_o.addr = {q_stat_i.wr_bank, pos_q};
  assign pix_wr_o.data = s_axis_tdata_i[7:0];

endmodule

`default_nettype wire

// ===== rtl/core/dcps_jobq.sv =====
// ----------------------------------------------------------------------------
// dcps_jobq
// Two-entry job queue; a slot stays held until the last beat of its block is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module dcps_jobq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire dcps_pkg::job_t      push_job_i,
  input  wire logic                pop_i,
  output dcps_pkg::job_t           head_o,
  output dcps_pkg::jobq_stat_t     stat_o
);
  import dcps_pkg::*;

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign head_o         = slot_q[rd_ptr_q];
  assign stat_o.full    = (cnt_q == 2'd2);
  assign stat_o.empty   = (cnt_q == 2'd0);
  assign stat_o.wr_bank = wr_ptr_q;
  assign stat_o.rd_bank = rd_ptr_q;

endmodule

`default_nettype wire

// ===== rtl/core/dcps_back.sv =====
// ----------------------------------------------------------------------------
// dcps_back
// Per block: sets the coefficient gap, then streams the corrected pixels (one found beat for extract).
// ----------------------------------------------------------------------------
`default_nettype none

module dcps_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [7:0]          cfg_data_i,
  input  wire dcps_pkg::pix_wr_t   pix_wr_i,
  input  wire dcps_pkg::job_t      head_i,
  input  wire dcps_pkg::jobq_stat_t q_stat_i,
  output logic                     pop_o,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [15:0]              m_axis_tdata_o,
  output logic                     m_axis_tlast_o
);
  import dcps_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StGap  = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;

  // two banks of one block each
  logic [7:0]             pix_mem [2*BlockPixels];
  logic [7:0]             rd_q;

  logic [7:0]             intensity_q;
  logic [1:0]             state_q;
  logic [PosW-1:0]        k_q;
  logic signed [CW:0]     diff_q;
  logic signed [DW-1:0]   d_q;
  logic signed [DW-1:0]   gap;
  logic signed [DiffWW-1:0] wd;

  logic                   s1_valid_q, s1_last_q, s1_ext_q, s1_found_q;
  logic signed [PW-1:0]   prod_q;

  res_t                   fifo_q [OutDepth];
  logic [OutPtrW-1:0]     fw_ptr_q, fr_ptr_q;
  logic [OutPtrW:0]       fcnt_q;
  logic                   credit_ok, issue, issue_last, fifo_rd;

  logic signed [TW-1:0]   pix_t, prod_t, round_t, t_sum;
  logic [7:0]             sat_pix;
  res_t                   res;

  always_ff @(posedge clk_i) begin
    if (pix_wr_i.en) pix_mem[pix_wr_i.addr] <= pix_wr_i.data;
    rd_q <= pix_mem[{q_stat_i.rd_bank, k_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q <= 8'd30;
    end else if (cfg_valid_i) begin
      intensity_q <= cfg_data_i;
    end
  end

  assign gap = DW'({intensity_q, {FracBits{1'b0}}});
  assign wd  = WTabD[k_q];

  assign credit_ok  = (fcnt_q + (OutPtrW+1)'(s1_valid_q)) < (OutPtrW+1)'(OutDepth);
  assign issue      = (state_q == StRun) && credit_ok;
  assign issue_last = head_i.kind || (k_q == PosW'(BlockPixels - 1));
  assign pop_o      = issue && issue_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q     <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (!q_stat_i.empty) state_q <= StGap;
        end
        StGap: begin
          k_q     <= '0;
          state_q <= StRun;
        end
        StRun: begin
          if (issue) begin
            k_q <= k_q + PosW'(1);
            if (issue_last) state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath regs, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) begin
      diff_q <= (CW+1)'(head_i.coef_b) - (CW+1)'(head_i.coef_a);
    end
    if (state_q == StGap) begin
      d_q <= head_i.msg_bit ? DW'(diff_q) + gap : DW'(diff_q) - gap;
    end
    if (issue) begin
      prod_q     <= PW'(d_q) * PW'(wd);
      s1_last_q  <= issue_last;
      s1_ext_q   <= head_i.kind;
      s1_found_q <= diff_q[CW];   // b - a negative: a > b
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  // pixel * 2^(2F+1) + delta + half, then round down and clamp
  assign pix_t   = $signed(TW'({rd_q, {Shift{1'b0}}}));
  assign prod_t  = TW'(prod_q);
  assign round_t = $signed(TW'({1'b1, {(2*FracBits){1'b0}}}));
  assign t_sum   = pix_t + prod_t + round_t;

  always_comb begin
    if (t_sum[TW-1]) begin
      sat_pix = 8'd0;
    end else if (|t_sum[TW-2:Shift+8]) begin
      sat_pix = 8'd255;
    end else begin
      sat_pix = t_sum[Shift+7:Shift];
    end
  end

  assign res.pixel = s1_ext_q ? 8'd0 : sat_pix;
  assign res.found = s1_ext_q && s1_found_q;
  assign res.last  = s1_last_q;

  // output queue doubles as the skid buffer
  assign fifo_rd = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) fifo_q[fw_ptr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_ptr_q <= '0;
      fr_ptr_q <= '0;
      fcnt_q   <= '0;
    end else begin
      if (s1_valid_q) fw_ptr_q <= fw_ptr_q + OutPtrW'(1);
      if (fifo_rd)    fr_ptr_q <= fr_ptr_q + OutPtrW'(1);
      fcnt_q <= fcnt_q + (OutPtrW+1)'(s1_valid_q) - (OutPtrW+1)'(fifo_rd);
    end
  end

  assign m_axis_tvalid_o = (fcnt_q != '0);
  assign m_axis_tdata_o  = {7'd0, fifo_q[fr_ptr_q].found, fifo_q[fr_ptr_q].pixel};
  assign m_axis_tlast_o  = fifo_q[fr_ptr_q].last;

endmodule

`default_nettype wire

// ===== rtl/core/dct_coefficient_pair_stego.sv =====
// ----------------------------------------------------------------------------
// dct_coefficient_pair_stego
// Hides or reads one bit per 8x8 block in the DCT pair (6,7) / (5,1).
// ----------------------------------------------------------------------------
// Pixels come in one beat per cycle, 64 per block, row-major; kind and the
// message bit count only on the 64th beat. An embed block returns 64 pixel
// beats, an extract block one beat carrying the found bit, both ending with
// tlast. The input side takes a beat every cycle while the two-entry job
// queue has room; each job holds one bank of the block buffer until the
// last result of its block is issued. The output side loads each job in
// its idle and gap states, then emits one beat per cycle (one memory read
// and one multiply each) while its output queue has room. The input side
// can take the next block while the output side works on the last one.
// Intensity may change only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dct_coefficient_pair_stego (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: intensity
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [7:0] pixel, [8] message_bit
  input  wire logic        s_axis_tuser_i,   // [0] kind
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] out_pixel, [8] found_bit
  output logic             m_axis_tlast_o
);
  import dcps_pkg::*;

  `include "dct_coefficient_pair_stego_assert.svh"

  logic       job_push, job_pop;
  job_t       push_job, head_job;
  jobq_stat_t q_stat;
  pix_wr_t    pix_wr;
  logic       found_beat, extract_beat;

  assign cfg_ready_o = 1'b1;

  dcps_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_stat_i        (q_stat),
    .push_o          (job_push),
    .push_job_o      (push_job),
    .pix_wr_o        (pix_wr)
  );

  dcps_jobq u_jobq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_job_i (push_job),
    .pop_i      (job_pop),
    .head_o     (head_job),
    .stat_o     (q_stat)
  );

  dcps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .pix_wr_i        (pix_wr),
    .head_i          (head_job),
    .q_stat_i        (q_stat),
    .pop_o           (job_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  assign found_beat   = m_axis_tvalid_o && m_axis_tdata_o[8];
  assign extract_beat = m_axis_tlast_o && (m_axis_tdata_o[7:0] == 8'd0);

  `DCPS_ASSERT(a_push_room, !(job_push && q_stat.full), "job pushed into full queue")
  `DCPS_ASSERT(a_pop_held, !(job_pop && q_stat.empty), "job popped from empty queue")
  `DCPS_ASSERT_IMP(a_found_beat, found_beat, extract_beat, "found bit on a non-extract beat")

endmodule

`default_nettype wire

// ===== verif/dct_coefficient_pair_stego_test.sv =====
// ----------------------------------------------------------------------------
// dct_coefficient_pair_stego_test
// Self-checking bench for the DCT coefficient pair stego block.
// ----------------------------------------------------------------------------
// Streams 8x8 pixel blocks in and predicts every output beat by recomputing
// the (6,7) and (5,1) coefficient sums in fixed point. Embed blocks expect 64
// reworked pixels, extract blocks one found bit. Runs several intensity
// settings, random gaps on both streams and one long output hold-off.
// ----------------------------------------------------------------------------

module dct_coefficient_pair_stego_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC       = 10;
  localparam int SHIFT      = 2 * FRAC + 1;
  localparam int NPIX       = 64;
  localparam int SETTLE     = 16;
  localparam int LONG_HOLD  = 400;
  localparam int STALL_CAP  = 3000;
  localparam int SHOW_FAILS = 10;

  typedef enum int {TEX_ZERO, TEX_FULL, TEX_NOISE, TEX_FLAT, TEX_BINARY, TEX_SOFT} texture_e;

  typedef struct {
    bit          kind;
    bit [7:0]    pix;
    bit          msg;
    int unsigned hold;
  } pixel_beat_t;

  typedef struct {
    bit [7:0] pix;
    bit       found;
    bit       last;
  } stego_beat_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i      = 8'd0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = 16'd0;  // [7:0] pixel, [8] message_bit
  logic        s_axis_tuser_i  = 1'b0;   // [0] kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;           // [7:0] out_pixel, [8] found_bit
  logic        m_axis_tlast_o;

  dct_coefficient_pair_stego dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------- predictor
  pixel_beat_t pixel_feed[$];
  stego_beat_t want_beats[$];
  pixel_beat_t cur_beat;

  longint   hi_basis [NPIX];   // basis (6,7), Q10
  longint   lo_basis [NPIX];   // basis (5,1), Q10
  bit [7:0] blk_pix  [NPIX];
  longint   acc_hi;
  longint   acc_lo;
  int       px_pos;
  bit [7:0] gap_setting;
  int       fail_count;

  // cos(k*pi/16) in Q30
  function automatic longint cos_pi16(int unsigned k);
    int unsigned m;
    m = k % 32;
    if (m > 16) m = 32 - m;
    if (m > 8) return -cos_pi16(16 - m);
    case (m)
      0: return 64'sd1073741824;
      1: return 64'sd1053110176;
      2: return 64'sd992008094;
      3: return 64'sd892783698;
      4: return 64'sd759250125;
      5: return 64'sd596538995;
      6: return 64'sd410903207;
      7: return 64'sd209476638;
      default: return 64'sd0;
    endcase
  endfunction

  // Q60 product down to Q10 (the /4 of the orthonormal scale included),
  // rounded half away from zero
  function automatic longint basis_q(int unsigned u, int unsigned v,
                                     int unsigned r, int unsigned c);
    longint prod;
    longint mag;
    longint q;
    prod = cos_pi16((2 * r + 1) * u) * cos_pi16((2 * c + 1) * v);
    mag  = (prod < 0) ? -prod : prod;
    q    = (mag + (64'sd1 <<< (61 - FRAC))) >>> (62 - FRAC);
    return (prod < 0) ? -q : q;
  endfunction

  task automatic absorb_pixel(input pixel_beat_t b);
    longint      a0, b0, sum, g, da2, db2, t;
    stego_beat_t w;
    blk_pix[px_pos] = b.pix;
    acc_hi += longint'(b.pix) * hi_basis[px_pos];
    acc_lo += longint'(b.pix) * lo_basis[px_pos];
    if (px_pos != NPIX - 1) begin
      px_pos++;
      return;
    end
    a0     = acc_hi;
    b0     = acc_lo;
    px_pos = 0;
    acc_hi = 0;
    acc_lo = 0;
    if (b.kind) begin
      w.pix   = 8'd0;
      w.found = (a0 > b0);
      w.last  = 1'b1;
      want_beats.push_back(w);
      return;
    end
    // doubled deltas keep the mean exact
    sum = a0 + b0;
    g   = longint'(gap_setting) * (64'sd1 <<< FRAC);
    if (b.msg) begin
      da2 = (sum + g) - 2 * a0;
      db2 = (sum - g) - 2 * b0;
    end else begin
      da2 = (sum - g) - 2 * a0;
      db2 = (sum + g) - 2 * b0;
    end
    for (int k = 0; k < NPIX; k++) begin
      t = (longint'(blk_pix[k]) <<< SHIFT) + da2 * hi_basis[k] + db2 * lo_basis[k]
          + (64'sd1 <<< (2 * FRAC));
      if (t < 0) w.pix = 8'd0;
      else if ((t >>> SHIFT) > 255) w.pix = 8'd255;
      else w.pix = 8'(t >>> SHIFT);
      w.found = 1'b0;
      w.last  = (k == NPIX - 1);
      want_beats.push_back(w);
    end
  endtask

  // ------------------------------------------------------------ pixel driver
  int unsigned src_wait;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      src_wait = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        absorb_pixel(cur_beat);
        src_wait = cur_beat.hold;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (src_wait > 0) begin
          src_wait--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pixel_feed.size() > 0) begin
          cur_beat = pixel_feed.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {7'd0, cur_beat.msg, cur_beat.pix};
          s_axis_tuser_i  <= cur_beat.kind;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------ result sink
  bit          sink_jitter;
  int unsigned holds_asked;
  int unsigned holds_done;
  int unsigned sink_wait;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_wait  = 0;
      holds_done = 0;
    end else begin
      if (holds_done != holds_asked) begin
        holds_done++;
        sink_wait = LONG_HOLD;
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (sink_jitter) sink_wait = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------- checker
  stego_beat_t head;
  int unsigned out_beats;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (want_beats.size() == 0) begin
        if (fail_count < SHOW_FAILS)
          $display("beat %0d: unexpected result pixel %0d found %0d last %0d",
                   out_beats, m_axis_tdata_o[7:0], m_axis_tdata_o[8], m_axis_tlast_o);
        fail_count++;
      end else begin
        head = want_beats.pop_front();
        if (m_axis_tdata_o[7:0] !== head.pix || m_axis_tdata_o[8] !== head.found ||
            m_axis_tlast_o !== head.last) begin
          if (fail_count < SHOW_FAILS)
            $display("beat %0d: expected pixel %0d found %0d last %0d, got %0d %0d %0d",
                     out_beats, head.pix, head.found, head.last,
                     m_axis_tdata_o[7:0], m_axis_tdata_o[8], m_axis_tlast_o);
          fail_count++;
        end
      end
      out_beats++;
    end
  end

  // --------------------------------------------------------------- watchdog
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_CAP) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------- stimulus
  task automatic queue_block(input bit kind, input bit msg, input texture_e tex,
                             input bit jitter);
    pixel_beat_t b;
    bit [7:0]    base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < NPIX; i++) begin
      case (tex)
        TEX_ZERO:   b.pix = 8'd0;
        TEX_FULL:   b.pix = 8'd255;
        TEX_FLAT:   b.pix = base;
        TEX_BINARY: b.pix = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        TEX_SOFT:   b.pix = 8'((int'(base) + $urandom_range(0, 6) > 255) ?
                                 255 : int'(base) + $urandom_range(0, 6));
        default:    b.pix = $urandom_range(0, 255);
      endcase
      // kind and message bit only count on the closing pixel
      b.kind = (i == NPIX - 1) ? kind : 1'($urandom_range(0, 1));
      b.msg  = (i == NPIX - 1) ? msg  : 1'($urandom_range(0, 1));
      b.hold = jitter ? idle_len() : 0;
      pixel_feed.push_back(b);
    end
  endtask

  task automatic drain();
    while (pixel_feed.size() != 0 || s_axis_tvalid_i || want_beats.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_gap(input bit [7:0] val);
    drain();
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gap_setting = val;
  endtask

  initial begin
    for (int i = 0; i < NPIX; i++) begin
      hi_basis[i] = basis_q(6, 7, i / 8, i % 8);
      lo_basis[i] = basis_q(5, 1, i / 8, i % 8);
    end
    acc_hi      = 0;
    acc_lo      = 0;
    px_pos      = 0;
    gap_setting = 8'd30;
    fail_count  = 0;
    out_beats   = 0;
    holds_asked = 0;
    sink_jitter = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: equal coefficients both ways, then the gap extremes
    queue_block(1'b0, 1'b1, TEX_ZERO, 1'b0);
    queue_block(1'b1, 1'b0, TEX_ZERO, 1'b0);
    set_gap(8'd0);
    sink_jitter = 1'b1;
    queue_block(1'b0, 1'b1, TEX_NOISE, 1'b1);
    set_gap(8'd255);
    queue_block(1'b0, 1'b0, TEX_BINARY, 1'b1);

    // two embed blocks fill the job queue under a long hold-off, the third stalls
    set_gap(8'($urandom_range(1, 254)));
    for (int j = 0; j < 3; j++)
      queue_block(j == 2, 1'($urandom_range(0, 1)),
                  texture_e'($urandom_range(TEX_FLAT, TEX_SOFT)), 1'b0);
    holds_asked++;
    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
